@@ src/gtg_pkg.sv @@
// Shared types, constants and helpers for the go-to-goal drive controller.
// Used by gtg_cordic and go_to_goal_drive_controller; no dependencies.
`default_nettype none
package gtg_pkg;

  localparam int unsigned CIN_W = 36;   // CORDIC operand width
  localparam int unsigned CX_W  = 56;   // CORDIC datapath width (operand << 16 plus growth)
  localparam int unsigned Z_W   = 20;   // angle accumulator, Q.16

  localparam logic [1:0] OP_GOAL = 2'd0;
  localparam logic [1:0] OP_POSE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] MODE_STOP  = 2'd0;
  localparam logic [1:0] MODE_DRIVE = 2'd1;
  localparam logic [1:0] MODE_TURN  = 2'd2;

  localparam logic [1:0] REG_WHEELBASE = 2'd0;
  localparam logic [1:0] REG_STEER_LIM = 2'd1;
  localparam logic [1:0] REG_GOAL_TOL  = 2'd2;

  localparam logic signed [Z_W-1:0] HALF_PI16 = 20'sd102944;
  localparam logic signed [16:0] PI13      = 17'sd25736;
  localparam logic signed [17:0] TWO_PI13  = 18'sd51472;
  localparam logic signed [30:0] INV_GAIN  = 31'sd652032874;
  localparam logic signed [30:0] DIV20_MUL = 31'sd52429;
  localparam logic signed [16:0] TURN_ERR  = 17'sd3277;
  localparam logic [33:0] NEAR_DIST  = 34'd32768;
  localparam logic [34:0] VEL_SAT_IN = 35'd81920;
  localparam logic [12:0] VEL_MAX    = 13'd4096;
  localparam logic [12:0] VEL_MIN    = 13'd205;

  function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:  r = 20'sd51472;
      5'd1:  r = 20'sd30385;
      5'd2:  r = 20'sd16055;
      5'd3:  r = 20'sd8150;
      5'd4:  r = 20'sd4091;
      5'd5:  r = 20'sd2047;
      5'd6:  r = 20'sd1024;
      5'd7:  r = 20'sd512;
      5'd8:  r = 20'sd256;
      5'd9:  r = 20'sd128;
      5'd10: r = 20'sd64;
      5'd11: r = 20'sd32;
      5'd12: r = 20'sd16;
      5'd13: r = 20'sd8;
      5'd14: r = 20'sd4;
      5'd15: r = 20'sd2;
      5'd16: r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q.16 angle to Q3.13, round half up, clamp to +-pi
  function automatic logic signed [15:0] to_q13(input logic signed [Z_W-1:0] z);
    logic signed [Z_W:0] a;
    a = ($signed({z[Z_W-1], z}) + 21'sd4) >>> 3;
    if (a > 21'sd25736) a = 21'sd25736;
    if (a < -21'sd25736) a = -21'sd25736;
    return a[15:0];
  endfunction

endpackage
`default_nettype wire

@@ src/gtg_cordic.sv @@
// Iterative vectoring CORDIC: one micro-rotation per cycle.
// Depends on gtg_pkg (widths, arctangent table).
`default_nettype none
module gtg_cordic import gtg_pkg::*; #(
  parameter int unsigned Steps = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [CIN_W-1:0] x_i,
  input  wire logic signed [CIN_W-1:0] y_i,
  output logic                        done_o,
  output logic signed [Z_W-1:0]       z_o,
  output logic signed [CX_W-1:0]      mag_o
);

  localparam int unsigned CNT_W = $clog2(Steps + 1);

  logic                   busy_q, done_q;
  logic [CNT_W-1:0]       cnt_q;
  logic signed [CX_W-1:0] x_q, y_q, xs, ys, xe, ye;
  logic signed [Z_W-1:0]  z_q;
  logic [4:0]             idx;

  assign idx = 5'(cnt_q);
  assign xs  = x_q >>> idx;
  assign ys  = y_q >>> idx;
  assign xe  = {{(CX_W-CIN_W-16){x_i[CIN_W-1]}}, x_i, 16'b0};
  assign ye  = {{(CX_W-CIN_W-16){y_i[CIN_W-1]}}, y_i, 16'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (x_i == '0 && y_i == '0) begin
          x_q    <= '0;
          y_q    <= '0;
          z_q    <= '0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          if (xe < 0 && ye >= 0) begin
            x_q <= ye;
            y_q <= -xe;
            z_q <= HALF_PI16;
          end else if (xe < 0) begin
            x_q <= -ye;
            y_q <= xe;
            z_q <= -HALF_PI16;
          end else begin
            x_q <= xe;
            y_q <= ye;
            z_q <= '0;
          end
        end
      end else if (busy_q) begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_lut(idx);
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_lut(idx);
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign z_o    = z_q;
  assign mag_o  = x_q;

endmodule
`default_nettype wire

@@ src/go_to_goal_drive_controller.sv @@
// Go-to-goal drive controller: goal/pose/tick items in, drive commands out.
// Depends on gtg_pkg and gtg_cordic.
//
//  channel | dir | handshake               | payload
//  in      | in  | in_valid_i/in_ready_o   | opcode, pos_x/y, quat_w/x/y/z
//  out     | out | out_valid_o/out_ready_i | motion_mode, velocity, steer_cmd, spin_rate
//  cfg     | in  | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Goal, idle-tick and unused beats are handled in S_IDLE itself. Pose beat:
// four quaternion products on the shared multiplier, then one CORDIC run.
// Tick beat: one CORDIC run for stop, turn or a drive without steering, and
// two CORDIC runs when steering is computed. The CORDIC unit and the single
// multiplier set the pace.
// Reset clears pose/goal state and config to defaults; a result held on a
// stalled output keeps the next tick in its final state with in_ready_o low.
`default_nettype none
module go_to_goal_drive_controller import gtg_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              motion_mode_o,
  output logic [12:0]             velocity_o,
  output logic signed [15:0]      steer_cmd_o,
  output logic signed [15:0]      spin_rate_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [30:0]        cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_QMUL, S_YAW_GO, S_YAW_WAIT, S_DIFF, S_TGT_WAIT, S_MAG_H, S_MAG_L,
    S_DIST, S_DECIDE, S_VEL, S_VCHK, S_STEER_GO, S_STEER_WAIT, S_OUT
  } state_e;

  state_e state_q;
  logic [2:0] k_q;
  logic armed_q, pose_seen_q, ov_q;
  logic [15:0] wb_q;
  logic [14:0] lim_q;
  logic [30:0] tol_q;
  logic signed [31:0] tx_q, ty_q, cx_q, cy_q;
  logic signed [15:0] yaw_q, qw_q, qx_q, qy_q, qz_q;
  logic signed [31:0] sy_acc_q, cy_acc_q;
  logic signed [16:0] err_q;
  logic [32:0] m_q;
  logic [63:0] acc_q;
  logic [33:0] dist_q;
  logic signed [48:0] prod_q, prod_d;
  logic signed [17:0] ma;
  logic signed [30:0] mb;
  logic [1:0] mode_q;
  logic [12:0] vel_q;
  logic signed [15:0] steer_q, spin_q;
  logic [1:0] mode_o_q;
  logic [12:0] vel_o_q;
  logic signed [15:0] steer_o_q, spin_o_q;

  logic cs_start, cs_done;
  logic signed [CIN_W-1:0] cs_x, cs_y;
  logic signed [Z_W-1:0] cs_z;
  logic signed [CX_W-1:0] cs_mag;

  logic signed [32:0] dx_w, dy_w;
  logic signed [31:0] dx_s, dy_s;
  logic signed [17:0] werr;
  logic signed [16:0] err_wrapped;
  logic signed [18:0] spin_t;
  logic [34:0] n_w;
  logic [63:0] dsum;
  logic signed [CIN_W-1:0] p36;
  logic signed [15:0] steer_raw, lim_s;

  gtg_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cs_start), .x_i(cs_x), .y_i(cs_y),
    .done_o(cs_done), .z_o(cs_z), .mag_o(cs_mag)
  );

  assign dx_w = {tx_q[31], tx_q} - {cx_q[31], cx_q};
  assign dy_w = {ty_q[31], ty_q} - {cy_q[31], cy_q};
  assign dx_s = (dx_w[32] != dx_w[31]) ? {dx_w[32], {31{~dx_w[32]}}} : dx_w[31:0];
  assign dy_s = (dy_w[32] != dy_w[31]) ? {dy_w[32], {31{~dy_w[32]}}} : dy_w[31:0];

  assign werr = {err_q[16], err_q} - {{2{yaw_q[15]}}, yaw_q};
  always_comb begin
    if (werr > 18'sd25736) err_wrapped = 17'(werr - TWO_PI13);
    else if (werr < -18'sd25736) err_wrapped = 17'(werr + TWO_PI13);
    else err_wrapped = werr[16:0];
  end

  assign spin_t = {{2{err_q[16]}}, err_q} + {err_q[16], err_q, 1'b0} + 19'sd2;
  assign n_w    = {1'b0, dist_q} + 35'd10;
  assign dsum   = acc_q + 64'(prod_q) + 64'd536870912;
  assign p36    = CIN_W'(prod_q);
  assign steer_raw = to_q13(cs_z);
  assign lim_s  = {1'b0, lim_q};

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_QMUL: begin
        case (k_q)
          3'd0: begin ma = 18'(qw_q); mb = 31'(qz_q); end
          3'd1: begin ma = 18'(qx_q); mb = 31'(qy_q); end
          3'd2: begin ma = 18'(qy_q); mb = 31'(qy_q); end
          3'd3: begin ma = 18'(qz_q); mb = 31'(qz_q); end
          default: ;
        endcase
      end
      S_MAG_H:  begin ma = {2'b0, m_q[32:17]}; mb = INV_GAIN; end
      S_MAG_L:  begin ma = {1'b0, m_q[16:0]};  mb = INV_GAIN; end
      S_DECIDE: begin ma = {1'b0, n_w[16:0]};  mb = DIV20_MUL; end
      S_VCHK:   begin ma = {2'b0, wb_q};       mb = 31'(err_q); end
      default: ;
    endcase
  end
  assign prod_d = ma * mb;

  // CORDIC operand select
  always_comb begin
    cs_start = 1'b0;
    cs_x = '0;
    cs_y = '0;
    case (state_q)
      S_YAW_GO: begin
        cs_start = 1'b1;
        cs_x = 36'sd268435456 - (CIN_W'(cy_acc_q) <<< 1);
        cs_y = CIN_W'(sy_acc_q) <<< 1;
      end
      S_DIFF: begin
        cs_start = 1'b1;
        cs_x = CIN_W'(dx_s);
        cs_y = CIN_W'(dy_s);
      end
      S_STEER_GO: begin
        cs_start = 1'b1;
        cs_x = signed'({7'b0, vel_q, 16'b0}) + signed'({9'b0, vel_q, 14'b0});
        cs_y = (p36 <<< 3) + (p36 <<< 2);
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      armed_q     <= 1'b0;
      pose_seen_q <= 1'b0;
      ov_q        <= 1'b0;
      wb_q        <= 16'd4096;
      lim_q       <= 15'd4915;
      tol_q       <= 31'd9830;
      tx_q        <= '0;
      ty_q        <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      yaw_q       <= '0;
      qw_q        <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      qz_q        <= '0;
      sy_acc_q    <= '0;
      cy_acc_q    <= '0;
      err_q       <= '0;
      m_q         <= '0;
      acc_q       <= '0;
      dist_q      <= '0;
      prod_q      <= '0;
      mode_q      <= MODE_STOP;
      vel_q       <= '0;
      steer_q     <= '0;
      spin_q      <= '0;
      mode_o_q    <= MODE_STOP;
      vel_o_q     <= '0;
      steer_o_q   <= '0;
      spin_o_q    <= '0;
    end else begin
      prod_q <= prod_d;
      if (ov_q && out_ready_i && state_q != S_OUT) ov_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WHEELBASE: wb_q  <= cfg_data_i[15:0];
          REG_STEER_LIM: lim_q <= cfg_data_i[14:0];
          REG_GOAL_TOL:  tol_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (opcode_i)
              OP_GOAL: begin
                tx_q    <= pos_x_i;
                ty_q    <= pos_y_i;
                armed_q <= 1'b1;
              end
              OP_POSE: begin
                cx_q  <= pos_x_i;
                cy_q  <= pos_y_i;
                qw_q  <= quat_w_i;
                qx_q  <= quat_x_i;
                qy_q  <= quat_y_i;
                qz_q  <= quat_z_i;
                k_q   <= '0;
                state_q <= S_QMUL;
              end
              OP_TICK: begin
                if (armed_q && pose_seen_q) state_q <= S_DIFF;
              end
              default: ;
            endcase
          end
        end
        S_QMUL: begin
          k_q <= k_q + 3'd1;
          case (k_q)
            3'd1: sy_acc_q <= 32'(prod_q);
            3'd2: sy_acc_q <= sy_acc_q + 32'(prod_q);
            3'd3: cy_acc_q <= 32'(prod_q);
            3'd4: begin
              cy_acc_q <= cy_acc_q + 32'(prod_q);
              state_q  <= S_YAW_GO;
            end
            default: ;
          endcase
        end
        S_YAW_GO: state_q <= S_YAW_WAIT;
        S_YAW_WAIT: begin
          if (cs_done) begin
            yaw_q       <= steer_raw;
            pose_seen_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_DIFF: state_q <= S_TGT_WAIT;
        S_TGT_WAIT: begin
          if (cs_done) begin
            err_q   <= 17'(steer_raw);
            m_q     <= cs_mag[48:16];
            state_q <= S_MAG_H;
          end
        end
        S_MAG_H: begin
          err_q   <= err_wrapped;
          state_q <= S_MAG_L;
        end
        S_MAG_L: begin
          acc_q   <= 64'(prod_q) << 17;
          state_q <= S_DIST;
        end
        S_DIST: begin
          dist_q  <= dsum[63:30];
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          steer_q <= '0;
          if (dist_q < {3'b0, tol_q}) begin
            mode_q  <= MODE_STOP;
            vel_q   <= '0;
            spin_q  <= '0;
            armed_q <= 1'b0;
            state_q <= S_OUT;
          end else if ((err_q >= TURN_ERR || err_q <= -TURN_ERR) && dist_q < NEAR_DIST) begin
            mode_q  <= MODE_TURN;
            vel_q   <= '0;
            spin_q  <= spin_t[17:2];
            state_q <= S_OUT;
          end else begin
            mode_q <= MODE_DRIVE;
            spin_q <= '0;
            if (n_w >= VEL_SAT_IN) begin
              vel_q   <= VEL_MAX;
              state_q <= S_VCHK;
            end else begin
              state_q <= S_VEL;
            end
          end
        end
        S_VEL: begin
          vel_q   <= prod_q[32:20];
          state_q <= S_VCHK;
        end
        S_VCHK: state_q <= (vel_q >= VEL_MIN) ? S_STEER_GO : S_OUT;
        S_STEER_GO: state_q <= S_STEER_WAIT;
        S_STEER_WAIT: begin
          if (cs_done) begin
            if (steer_raw > lim_s) steer_q <= lim_s;
            else if (steer_raw < -lim_s) steer_q <= -lim_s;
            else steer_q <= steer_raw;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ov_q || out_ready_i) begin
            ov_q      <= 1'b1;
            mode_o_q  <= mode_q;
            vel_o_q   <= vel_q;
            steer_o_q <= steer_q;
            spin_o_q  <= spin_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = ov_q;
  assign motion_mode_o = mode_o_q;
  assign velocity_o    = vel_o_q;
  assign steer_cmd_o   = steer_o_q;
  assign spin_rate_o   = spin_o_q;

endmodule
`default_nettype wire

@@ src/gtg_checker.sv @@
// Port-level checks for go_to_goal_drive_controller, bound to the top level.
// Depends on gtg_pkg (mode codes).
`default_nettype none
module gtg_checker import gtg_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [1:0]        motion_mode_o,
  input wire logic [12:0]       velocity_o,
  input wire logic signed [15:0] steer_cmd_o,
  input wire logic signed [15:0] spin_rate_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(motion_mode_o)
      && $stable(velocity_o) && $stable(steer_cmd_o) && $stable(spin_rate_o))
    else $error("output beat changed while stalled");

  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_mode_o == MODE_STOP |->
      velocity_o == '0 && steer_cmd_o == '0 && spin_rate_o == '0)
    else $error("stop beat carries motion");

  a_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_mode_o == MODE_TURN |-> velocity_o == '0 && steer_cmd_o == '0)
    else $error("turn beat carries drive");

  a_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_mode_o == MODE_DRIVE |-> spin_rate_o == '0 && velocity_o <= VEL_MAX)
    else $error("drive beat malformed");

  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> motion_mode_o <= MODE_TURN)
    else $error("bad motion mode");

endmodule

bind go_to_goal_drive_controller gtg_checker u_gtg_checker (.*);
`default_nettype wire

@@ dv/tb_go_to_goal_drive_controller.sv @@
// Testbench for go_to_goal_drive_controller: goal, pose and tick beats in,
// drive commands out, checked against an in-bench fixed-point predictor.
// Depends on gtg_pkg and the controller RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_go_to_goal_drive_controller;
  import gtg_pkg::*;

  typedef struct packed {
    logic [1:0]         mode;
    logic [12:0]        vel;
    logic signed [15:0] steer;
    logic signed [15:0] spin;
  } cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         opcode_i = OP_GOAL;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         motion_mode_o;
  logic [12:0]        velocity_o;
  logic signed [15:0] steer_cmd_o;
  logic signed [15:0] spin_rate_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = REG_WHEELBASE;
  logic [30:0]        cfg_data_i = '0;

  go_to_goal_drive_controller dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state
  longint wb_q = 4096, slim_q = 4915, tol_q = 9830;
  longint tgt_x, tgt_y, cur_x, cur_y, cur_yaw;
  bit     armed_q, pose_q;
  cmd_t   cmd_q[$];
  int     fails = 0;
  int     send_idle = 0, recv_stall = 0;
  bit     hold_off = 1'b0;
  longint cycles = 0;

  function automatic longint sh_r(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint vec_angle(longint xi, longint yi, output longint mag);
    longint x, y, z, t, xs, ys;
    longint tab[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
    z = 0;
    if (xi == 0 && yi == 0) begin
      mag = 0;
      return 0;
    end
    x = xi * 65536;
    y = yi * 65536;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 102944;
      end else begin
        x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = sh_r(x, i);
      ys = sh_r(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += tab[i];
      end else begin
        x = x - ys; y = y + xs; z -= tab[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint q13_of(longint z);
    longint a;
    a = sh_r(z + 4, 3);
    if (a > 25736) a = 25736;
    if (a < -25736) a = -25736;
    return a;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic predict_beat(logic [1:0] op, longint px, longint py,
                              longint qw, longint qx, longint qy, longint qz);
    longint dx, dy, mag, err, dlen, vel, steer, spin, sy, cy;
    cmd_t c;
    if (op == OP_GOAL) begin
      tgt_x = px; tgt_y = py; armed_q = 1;
    end else if (op == OP_POSE) begin
      sy = 2 * (qw * qz + qx * qy);
      cy = (64'sd1 << 28) - 2 * (qy * qy + qz * qz);
      cur_x = px; cur_y = py;
      cur_yaw = q13_of(vec_angle(cy, sy, mag));
      pose_q = 1;
    end else if (op == OP_TICK && armed_q && pose_q) begin
      dx = clip32(tgt_x - cur_x);
      dy = clip32(tgt_y - cur_y);
      err = q13_of(vec_angle(dx, dy, mag));
      dlen = ((mag >> 16) * 64'd652032874 + (64'd1 << 29)) >> 30;
      err -= cur_yaw;
      if (err > 25736) err -= 51472;
      if (err < -25736) err += 51472;
      vel = 0; steer = 0; spin = 0;
      if (dlen < tol_q) begin
        c.mode = MODE_STOP;
        armed_q = 0;
      end else if ((err >= 3277 || err <= -3277) && dlen < 32768) begin
        c.mode = MODE_TURN;
        spin = sh_r(3 * err + 2, 2);
        if (spin > 32767) spin = 32767;
        if (spin < -32768) spin = -32768;
      end else begin
        c.mode = MODE_DRIVE;
        vel = (dlen + 10) / 20;
        if (vel > 4096) vel = 4096;
        if (vel >= 205) steer = q13_of(vec_angle(vel * 81920, wb_q * 12 * err, mag));
        if (steer > slim_q) steer = slim_q;
        if (steer < -slim_q) steer = -slim_q;
      end
      c.vel = vel[12:0];
      c.steer = steer[15:0];
      c.spin = spin[15:0];
      cmd_q.push_back(c);
    end
  endtask

  // one beat on the input channel; valid stays up for a following beat
  task automatic send_beat(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                           logic [15:0] qw = 0, logic [15:0] qx = 0,
                           logic [15:0] qy = 0, logic [15:0] qz = 0);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    opcode_i <= op; pos_x_i <= px; pos_y_i <= py;
    quat_w_i <= qw; quat_x_i <= qx; quat_y_i <= qy; quat_z_i <= qz;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beat(op, $signed(px), $signed(py), $signed(qw), $signed(qx),
                 $signed(qy), $signed(qz));
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall);
    if (out_valid_o && out_ready_i) begin
      if (cmd_q.size() == 0) begin
        $error("unexpected drive command mode=%0d", motion_mode_o);
        fails++;
      end else begin
        cmd_t e;
        e = cmd_q.pop_front();
        if (motion_mode_o !== e.mode) begin
          $error("motion_mode exp %0d got %0d", e.mode, motion_mode_o); fails++;
        end
        if (velocity_o !== e.vel) begin
          $error("velocity exp %0d got %0d", e.vel, velocity_o); fails++;
        end
        if (steer_cmd_o !== e.steer) begin
          $error("steer_cmd exp %0d got %0d", e.steer, steer_cmd_o); fails++;
        end
        if (spin_rate_o !== e.spin) begin
          $error("spin_rate exp %0d got %0d", e.spin, spin_rate_o); fails++;
        end
      end
    end
  end

  initial begin
    wait (cycles > 1500000);
    $display("== FAIL ==");
    $finish;
  end

  task automatic drain();
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WHEELBASE: wb_q = val[15:0];
      REG_STEER_LIM: slim_q = val[14:0];
      REG_GOAL_TOL:  tol_q = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd_quat();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [31:0] rnd_pos();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(131072)) - 65536);
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  task automatic test_directed();
    send_beat(OP_TICK, 0, 0);                  // not armed, no pose
    send_beat(OP_GOAL, 32'h7fffffff, 32'h80000000);
    send_beat(OP_TICK, 0, 0);                  // armed, no pose yet
    send_beat(OP_POSE, 32'h80000000, 32'h7fffffff, 16'sd16384, 0, 0, 0);
    send_beat(OP_TICK, 0, 0);                  // saturated differences
    send_beat(OP_POSE, 0, 0, 0, 0, 0, 16'sd16384);
    send_beat(OP_GOAL, 0, 0);
    send_beat(OP_TICK, 0, 0);                  // zero vector, reached
    send_beat(OP_TICK, 0, 0);                  // disarmed
    send_beat(OP_GOAL, 32'd20000, 0);
    send_beat(OP_POSE, 0, 0, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_beat(OP_TICK, 0, 0);                  // turn in place
    send_beat(OP_GOAL, -32'sd100000, 32'd3000);
    send_beat(OP_TICK, 0, 0);
    send_beat(OP_POSE, 0, 0, 16'sd16384, 0, 0, 0);
    send_beat(OP_GOAL, 32'd200000, 32'd300000);
    send_beat(OP_TICK, 0, 0);                  // drive with steering
    send_beat(OP_GOAL, 32'd12000, 32'd100);
    send_beat(OP_TICK, 0, 0);                  // slow drive, steering computed
    send_beat(2'd3, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_beat(OP_GOAL, 32'd5000000, -32'sd5000000);
    send_beat(OP_TICK, 0, 0);
    in_valid_i <= 1'b0;
    drain();
  endtask

  task automatic test_random(int n);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: op = OP_GOAL;
        2, 3, 4: op = OP_POSE;
        9: op = ($urandom_range(3) == 0) ? 2'd3 : OP_TICK;
        default: op = OP_TICK;
      endcase
      send_beat(op, rnd_pos(), rnd_pos(), rnd_quat(), rnd_quat(), rnd_quat(), rnd_quat());
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_beat(OP_GOAL, 32'd900000, 32'd900000);
        send_beat(OP_POSE, 0, 0, 16'sd16384, 0, 0, 0);
        repeat (6) send_beat(OP_TICK, 0, 0);
        in_valid_i <= 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_reg(REG_WHEELBASE, 31'd65535);
    write_reg(REG_STEER_LIM, 31'd25736);
    write_reg(REG_GOAL_TOL, 31'd0);
    test_random(250);
    drain();
    send_idle = 46;
    write_reg(REG_WHEELBASE, 31'd1);
    write_reg(REG_STEER_LIM, 31'd0);
    write_reg(REG_GOAL_TOL, 31'h7fffffff);
    test_random(100);
    drain();
    send_idle = 0; recv_stall = 46;
    write_reg(REG_WHEELBASE, 31'd4096);
    write_reg(REG_STEER_LIM, 31'd4915);
    write_reg(REG_GOAL_TOL, 31'd9830);
    test_random(300);
    drain();
    send_idle = 35; recv_stall = 35;
    write_reg(REG_WHEELBASE, 31'd2000);
    write_reg(REG_STEER_LIM, 31'd12000);
    write_reg(REG_GOAL_TOL, 31'd70000);
    test_random(300);
    drain();
    send_idle = 0; recv_stall = 0;
    test_backpressure();
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
